### design/msq_pkg.sv
// shared types, constants and case tables for the marching squares cell core
`timescale 1ns / 1ps
`default_nettype none
package msq_pkg;

  localparam int GridSizeDef = 1024;
  localparam int NumLanes    = 4;
  localparam int DivSteps    = 17;
  localparam int StepsPerStg = 3;
  localparam int DivStages   = (DivSteps + StepsPerStg - 1) / StepsPerStg;

  // edge codes, also the lane numbers of the divider
  localparam logic [1:0] SideLeft   = 2'd0;
  localparam logic [1:0] SideRight  = 2'd1;
  localparam logic [1:0] SideBottom = 2'd2;
  localparam logic [1:0] SideTop    = 2'd3;

  // output tdata layout
  localparam int OutSideLo = 0;
  localparam int OutColLo  = 2;
  localparam int OutRowLo  = 28;
  localparam int OutIdxLo  = 54;
  localparam int OutWidth  = 56;
  localparam int InWidth   = 184;

  typedef struct packed {
    logic [3:0] idx;
    logic [9:0] col;
    logic [9:0] row;
  } cell_tag_t;

  // saturation limit of a position
  function automatic logic [25:0] msq_pos_lim(input int grid);
    longint lim;
    begin
      lim = longint'(grid - 1) <<< 16;
      if (lim > 64'h3FF_FFFF) lim = 64'h3FF_FFFF;
      msq_pos_lim = lim[25:0];
    end
  endfunction

  // number of crossings for a case index
  function automatic logic [2:0] msq_count(input logic [3:0] idx);
    begin
      case (idx)
        4'd0, 4'd15: msq_count = 3'd0;
        4'd6, 4'd9:  msq_count = 3'd4;
        default:     msq_count = 3'd2;
      endcase
    end
  endfunction

  // edge of the k-th crossing for a case index
  function automatic logic [1:0] msq_side(input logic [3:0] idx, input logic [1:0] k);
    logic [7:0] s;
    begin
      case (idx)
        4'd1:    s = {SideLeft,   SideLeft,   SideBottom, SideLeft};
        4'd2:    s = {SideLeft,   SideLeft,   SideBottom, SideRight};
        4'd3:    s = {SideLeft,   SideLeft,   SideRight,  SideLeft};
        4'd4:    s = {SideLeft,   SideLeft,   SideTop,    SideLeft};
        4'd5:    s = {SideLeft,   SideLeft,   SideBottom, SideTop};
        4'd6:    s = {SideBottom, SideRight,  SideTop,    SideLeft};
        4'd7:    s = {SideLeft,   SideLeft,   SideRight,  SideTop};
        4'd8:    s = {SideLeft,   SideLeft,   SideRight,  SideTop};
        4'd9:    s = {SideLeft,   SideBottom, SideRight,  SideTop};
        4'd10:   s = {SideLeft,   SideLeft,   SideBottom, SideTop};
        4'd11:   s = {SideLeft,   SideLeft,   SideLeft,   SideTop};
        4'd12:   s = {SideLeft,   SideLeft,   SideRight,  SideLeft};
        4'd13:   s = {SideLeft,   SideLeft,   SideBottom, SideRight};
        4'd14:   s = {SideLeft,   SideLeft,   SideBottom, SideLeft};
        default: s = 8'd0;
      endcase
      msq_side = s[2*k +: 2];
    end
  endfunction

endpackage
`default_nettype wire

### design/msq_frac.sv
// pipelined restoring divider, one lane per edge, quotient bits spread over the stages
`timescale 1ns / 1ps
`default_nettype none
module msq_frac
  import msq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  wire cell_tag_t  tag_i,
  input  wire logic [NumLanes-1:0][31:0] num_i,
  input  wire logic [NumLanes-1:0][31:0] den_i,
  output logic            valid_o,
  output cell_tag_t       tag_o,
  output logic [NumLanes-1:0][16:0] frac_o
);

  logic      [DivStages:0] vld_q;
  cell_tag_t [DivStages:0] tag_q;
  logic [DivStages:0][NumLanes-1:0][31:0] rem_q;
  logic [DivStages:0][NumLanes-1:0][31:0] den_q;
  logic [DivStages:0][NumLanes-1:0][16:0] quo_q;

  // entry stage: numerator is the first partial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stg
    logic [NumLanes-1:0][31:0] rem_d;
    logic [NumLanes-1:0][16:0] quo_d;

    // up to three compare and subtract steps per lane
    always_comb begin
      logic [32:0] rs;
      logic [31:0] r;
      logic [16:0] q;
      for (int l = 0; l < NumLanes; l++) begin
        r = rem_q[s][l];
        q = quo_q[s][l];
        for (int t = 0; t < StepsPerStg; t++) begin
          if (s * StepsPerStg + t < DivSteps) begin
            rs = (s * StepsPerStg + t == 0) ? {1'b0, r} : {r, 1'b0};
            if (rs >= {1'b0, den_q[s][l]}) begin
              rs = rs - {1'b0, den_q[s][l]};
              q  = {q[15:0], 1'b1};
            end else begin
              q  = {q[15:0], 1'b0};
            end
            r = rs[31:0];
          end
        end
        rem_d[l] = r;
        quo_d[l] = q;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s+1] <= tag_q[s];
        rem_q[s+1] <= rem_d;
        den_q[s+1] <= den_q[s];
        quo_q[s+1] <= quo_d;
      end
    end
  end

  assign valid_o = vld_q[DivStages];
  assign tag_o   = tag_q[DivStages];
  assign frac_o  = quo_q[DivStages];

endmodule
`default_nettype wire

### design/msq_emit.sv
// holds one finished cell, hands out its crossing points one per cycle while tready
`timescale 1ns / 1ps
`default_nettype none
module msq_emit
  import msq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [3:0] idx_i,
  input  wire logic [NumLanes-1:0][25:0] col_i,
  input  wire logic [NumLanes-1:0][25:0] row_i,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [OutWidth-1:0] m_axis_tdata, // edge_side, cross_col, cross_row, point_index
  output logic            m_axis_tlast
);

  logic       hold_q;
  logic [3:0] idx_q;
  logic [1:0] k_q;
  logic [NumLanes-1:0][25:0] col_q;
  logic [NumLanes-1:0][25:0] row_q;
  logic [2:0] cnt;
  logic [1:0] side;
  logic       is_last;
  logic       fire;
  logic       load;

  // current point
  assign cnt     = msq_count(idx_q);
  assign side    = msq_side(idx_q, k_q);
  assign is_last = ({1'b0, k_q} == cnt - 3'd1);
  assign fire    = hold_q && m_axis_tready;
  assign ready_o = !hold_q || (fire && is_last);
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      k_q    <= 2'd0;
    end else if (load) begin
      hold_q <= (msq_count(idx_i) != 3'd0);
      k_q    <= 2'd0;
    end else if (fire) begin
      if (is_last) hold_q <= 1'b0;
      k_q <= k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_q <= idx_i;
      col_q <= col_i;
      row_q <= row_i;
    end
  end

  assign m_axis_tvalid = hold_q;
  assign m_axis_tlast  = is_last;
  assign m_axis_tdata  = {k_q, row_q[side], col_q[side], side};

endmodule
`default_nettype wire

### design/marching_squares_cell_contour_core.sv
// marching squares cell core: case index, edge fractions, crossing points
// path: input register, seventeen-step divider per edge lane (most of the latency),
// position register, point emitter; a cell enters every cycle unless the emitter
// holds the pipeline; output gives one point per cycle while tready, so a cell with n
// crossings (at most 4) stalls the input side until its last point is taken
// reset: asynchronous, active low; clears all valid bits, pipeline empty
`timescale 1ns / 1ps
`default_nettype none
module marching_squares_cell_contour_core
  import msq_pkg::*;
#(
  parameter int GRID_SIZE = GridSizeDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // corner_lb, corner_rb, corner_lt, corner_rt, iso_level, cell_col, cell_row
  input  wire logic [InWidth-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // edge_side, cross_col, cross_row, point_index
  output logic [OutWidth-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast
);

  localparam logic [26:0] PosLim = {1'b0, msq_pos_lim(GRID_SIZE)};

  logic en;
  logic emit_rdy;

  // input register
  logic        in_vld_q;
  logic [31:0] lb_q, rb_q, lt_q, rt_q, lv_q;
  logic [9:0]  col_q, row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lb_q  <= s_axis_tdata[31:0];
      rb_q  <= s_axis_tdata[63:32];
      lt_q  <= s_axis_tdata[95:64];
      rt_q  <= s_axis_tdata[127:96];
      lv_q  <= s_axis_tdata[159:128];
      col_q <= s_axis_tdata[169:160];
      row_q <= s_axis_tdata[179:170];
    end
  end

  // distance between two signed samples
  function automatic logic [31:0] absdiff(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] d;
    begin
      d = {x[31], x} - {y[31], y};
      absdiff = d[32] ? 32'(-d) : d[31:0];
    end
  endfunction

  // case index and per-edge numerators and divisors
  cell_tag_t tag;
  logic [NumLanes-1:0][31:0] num, den;

  always_comb begin
    tag.idx = {$signed(rt_q) > $signed(lv_q), $signed(lt_q) > $signed(lv_q),
               $signed(rb_q) > $signed(lv_q), $signed(lb_q) > $signed(lv_q)};
    tag.col = col_q;
    tag.row = row_q;
    num[SideLeft]   = absdiff(lv_q, lb_q);
    den[SideLeft]   = absdiff(lt_q, lb_q);
    num[SideRight]  = absdiff(lv_q, rb_q);
    den[SideRight]  = absdiff(rt_q, rb_q);
    num[SideBottom] = absdiff(lv_q, lb_q);
    den[SideBottom] = absdiff(rb_q, lb_q);
    num[SideTop]    = absdiff(lv_q, lt_q);
    den[SideTop]    = absdiff(rt_q, lt_q);
  end

  logic      div_vld;
  cell_tag_t div_tag;
  logic [NumLanes-1:0][16:0] frac;

  msq_frac u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_vld_q),
    .tag_i   (tag),
    .num_i   (num),
    .den_i   (den),
    .valid_o (div_vld),
    .tag_o   (div_tag),
    .frac_o  (frac)
  );

  // saturate a position to the grid
  function automatic logic [25:0] sat(input logic [26:0] p);
    begin
      sat = (p > PosLim) ? PosLim[25:0] : p[25:0];
    end
  endfunction

  // crossing positions for every edge
  logic [NumLanes-1:0][25:0] pc_d, pr_d;
  logic [26:0] cb, rbase;

  always_comb begin
    cb    = {1'b0, div_tag.col, 16'd0};
    rbase = {1'b0, div_tag.row, 16'd0};
    pc_d[SideLeft]   = sat(cb);
    pr_d[SideLeft]   = sat(rbase + {10'd0, frac[SideLeft]});
    pc_d[SideRight]  = sat(cb + 27'h1_0000);
    pr_d[SideRight]  = sat(rbase + {10'd0, frac[SideRight]});
    pc_d[SideBottom] = sat(cb + {10'd0, frac[SideBottom]});
    pr_d[SideBottom] = sat(rbase);
    pc_d[SideTop]    = sat(cb + {10'd0, frac[SideTop]});
    pr_d[SideTop]    = sat(rbase + 27'h1_0000);
  end

  logic        pos_vld_q;
  logic [3:0]  pos_idx_q;
  logic [NumLanes-1:0][25:0] pc_q, pr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q <= 1'b0;
    end else if (en) begin
      pos_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_idx_q <= div_tag.idx;
      pc_q      <= pc_d;
      pr_q      <= pr_d;
    end
  end

  // whole pipeline moves unless the last stage is stuck
  assign en            = !pos_vld_q || emit_rdy;
  assign s_axis_tready = en;

  msq_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (pos_vld_q),
    .ready_o       (emit_rdy),
    .idx_i         (pos_idx_q),
    .col_i         (pc_q),
    .row_i         (pr_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

### design/msq_checker.sv
// port-level checks on the point stream of the cell core
`timescale 1ns / 1ps
`default_nettype none
module msq_checker
  import msq_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutWidth-1:0] m_axis_tdata,
  input wire logic                m_axis_tlast
);

  logic       fire;
  logic [1:0] pidx;

  assign fire = m_axis_tvalid && m_axis_tready;
  assign pidx = m_axis_tdata[OutIdxLo +: 2];

  // a waiting point is not withdrawn
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("point withdrawn while stalled");

  // a cell never ends halfway: more points follow at once
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !m_axis_tlast |=> m_axis_tvalid)
    else $error("cell points broken off");

  // points of a cell count up by one
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !m_axis_tlast |=> pidx == $past(pidx) + 2'd1)
    else $error("point order wrong");

  // a cell has two or four points
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> pidx == 2'd1 || pidx == 2'd3)
    else $error("cell ends on wrong point");

endmodule

bind marching_squares_cell_contour_core msq_checker u_msq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### sim/tb_marching_squares_cell_contour_core.sv
// self-checking testbench for the marching squares cell contour core
`timescale 1ns / 1ps
module tb_marching_squares_cell_contour_core;
  import msq_pkg::*;

  typedef struct packed {
    logic [1:0]  side;
    logic [25:0] ccol;
    logic [25:0] crow;
    logic [1:0]  pidx;
    logic        last;
  } crossing_t;

  typedef struct {
    logic signed [31:0] lb, rb, lt, rt, lvl;
    logic [9:0] col, row;
    int         n_exp;   // -1: no typed-in expectation, else count of points
    crossing_t  pts[4];
  } cell_row_t;

  localparam int Dirs = 24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InWidth-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;
  logic m_axis_tlast;

  crossing_t crossing_q[$];
  int  fails = 0;
  int  phase = 0;
  cell_row_t dir_tab[Dirs];

  always #1 clk_i = ~clk_i;

  marching_squares_cell_contour_core i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // crossing fraction from corner a towards corner b, Q1.16
  function automatic longint edge_fraction(longint a, longint b, longint lvl);
    longint num, den, q;
    num = (lvl - a < 0) ? a - lvl : lvl - a;
    den = (b - a < 0) ? a - b : b - a;
    if (den == 0) return 0;
    q = (num << 16) / den;
    return (q > 65536) ? 65536 : q;
  endfunction

  function automatic logic [25:0] clamp_pos(longint p);
    longint lim;
    lim = longint'(GridSizeDef - 1) << 16;
    if (lim > 64'h3FF_FFFF) lim = 64'h3FF_FFFF;
    return (p > lim) ? lim[25:0] : p[25:0];
  endfunction

  // push the crossings of one cell in the order of the case table
  task automatic predict_crossings(input cell_row_t c);
    logic [1:0] sides[4];
    logic [3:0] ci;
    longint lb, rb, lt, rt, lv, cc, rr;
    int n;
    crossing_t x;
    lb = c.lb; rb = c.rb; lt = c.lt; rt = c.rt; lv = c.lvl;
    ci = {rt > lv, lt > lv, rb > lv, lb > lv};
    n = 2;
    sides = '{SideLeft, SideLeft, SideLeft, SideLeft};
    case (ci)
      4'd1, 4'd14: sides = '{SideLeft, SideBottom, SideLeft, SideLeft};
      4'd2, 4'd13: sides = '{SideRight, SideBottom, SideLeft, SideLeft};
      4'd3, 4'd12: sides = '{SideLeft, SideRight, SideLeft, SideLeft};
      4'd4:        sides = '{SideLeft, SideTop, SideLeft, SideLeft};
      4'd5:        sides = '{SideTop, SideBottom, SideLeft, SideLeft};
      4'd6: begin
        sides = '{SideLeft, SideTop, SideRight, SideBottom}; n = 4;
      end
      4'd7, 4'd8:  sides = '{SideTop, SideRight, SideLeft, SideLeft};
      4'd9: begin
        sides = '{SideTop, SideRight, SideBottom, SideLeft}; n = 4;
      end
      4'd10:       sides = '{SideTop, SideBottom, SideLeft, SideLeft};
      4'd11:       sides = '{SideTop, SideLeft, SideLeft, SideLeft};
      default:     n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      cc = longint'(c.col) << 16;
      rr = longint'(c.row) << 16;
      case (sides[k])
        SideLeft:   rr += edge_fraction(lb, lt, lv);
        SideRight: begin
          cc += 65536; rr += edge_fraction(rb, rt, lv);
        end
        SideBottom: cc += edge_fraction(lb, rb, lv);
        default: begin
          cc += edge_fraction(lt, rt, lv); rr += 65536;
        end
      endcase
      x.side = sides[k];
      x.ccol = clamp_pos(cc);
      x.crow = clamp_pos(rr);
      x.pidx = k[1:0];
      x.last = (k == n - 1);
      crossing_q.push_back(x);
    end
  endtask

  function automatic cell_row_t mk(int lb, int rb, int lt, int rt, int lvl,
                                   int col, int row);
    cell_row_t c;
    c.lb = lb; c.rb = rb; c.lt = lt; c.rt = rt; c.lvl = lvl;
    c.col = col[9:0]; c.row = row[9:0]; c.n_exp = -1;
    return c;
  endfunction

  function automatic int rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  // drive one cell transaction and record its crossings
  task automatic send_cell(input cell_row_t c);
    int gap;
    gap = (phase == 0) ? 10 : (phase == 1) ? 77 : 0;
    while ($urandom_range(0, 99) < gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, c.row, c.col, c.lvl, c.rt, c.lt, c.rb, c.lb};
    if (c.n_exp >= 0)
      for (int k = 0; k < c.n_exp; k++) crossing_q.push_back(c.pts[k]);
    else
      predict_crossings(c);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // receiver stall pattern and checker
  always @(posedge clk_i) begin
    crossing_t got, want;
    int stall;
    stall = (phase == 0) ? 77 : (phase == 1) ? 10 : 0;
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) >= stall);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.side = m_axis_tdata[OutSideLo +: 2];
      got.ccol = m_axis_tdata[OutColLo +: 26];
      got.crow = m_axis_tdata[OutRowLo +: 26];
      got.pidx = m_axis_tdata[OutIdxLo +: 2];
      got.last = m_axis_tlast;
      if (crossing_q.size() == 0) begin
        $error("unexpected point %p", got);
        fails++;
      end else begin
        want = crossing_q.pop_front();
        if (got.side != want.side) begin
          $error("edge_side exp %0d got %0d", want.side, got.side); fails++;
        end
        if (got.ccol != want.ccol) begin
          $error("cross_col exp %h got %h", want.ccol, got.ccol); fails++;
        end
        if (got.crow != want.crow) begin
          $error("cross_row exp %h got %h", want.crow, got.crow); fails++;
        end
        if (got.pidx != want.pidx) begin
          $error("point_index exp %0d got %0d", want.pidx, got.pidx); fails++;
        end
        if (got.last != want.last) begin
          $error("last_point exp %0d got %0d", want.last, got.last); fails++;
        end
      end
    end
  end

  initial begin
    cell_row_t c;
    int drained;
    // empty cases, typed in
    dir_tab[0] = mk(0, 0, 0, 0, 0, 0, 0); dir_tab[0].n_exp = 0;
    dir_tab[1] = mk(-1, -1, -1, -1, 32'h8000_0000, 5, 5); dir_tab[1].n_exp = 0;
    // case 1 at origin, level halfway: typed in
    dir_tab[2] = mk(32'h0002_0000, 0, 0, 0, 32'h0001_0000, 0, 0);
    dir_tab[2].n_exp = 2;
    dir_tab[2].pts[0] = '{SideLeft, 26'd0, 26'h0_8000, 2'd0, 1'b0};
    dir_tab[2].pts[1] = '{SideBottom, 26'h0_8000, 26'd0, 2'd1, 1'b1};
    // every non-empty case index, saddles included
    for (int i = 3; i < 17; i++) begin
      int ci;
      ci = i - 2;
      dir_tab[i] = mk(ci[0] ? 32'h0003_0000 : -32'sh0001_0000,
                      ci[1] ? 32'h0005_0000 : -32'sh0002_0000,
                      ci[2] ? 32'h0001_0001 : -32'sh0007_0000,
                      ci[3] ? 32'h0009_0000 : -32'sh0000_0001,
                      0, i * 37, 1000 - i * 11);
    end
    // extremes of samples, level and indices
    dir_tab[17] = mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 1022, 1022);
    dir_tab[18] = mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFE, 1023, 0);
    dir_tab[19] = mk(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     0, 0, 1023);
    dir_tab[20] = mk(1, 0, 0, 0, 0, 1021, 1021);
    dir_tab[21] = mk(0, 1, 1, 0, 0, 1022, 0);
    dir_tab[22] = mk(-5, 5, 5, -5, 0, 512, 511);
    dir_tab[23] = mk(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h5555_5555,
                     32'hAAAA_AAAA, 341, 682);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_cell(dir_tab[i]);
    // random cells in three idling phases
    for (int p = 0; p < 3; p++) begin
      phase = p;
      for (int i = 0; i < 36; i++) begin
        c = mk(rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
               $urandom_range(0, 1023), $urandom_range(0, 1023));
        if ($urandom_range(0, 3) != 0) c.lvl = $signed($urandom_range(0, 32'h0002_0000))
                                                 - 32'sh0001_0000;
        send_cell(c);
      end
    end
    s_axis_tvalid <= 1'b0;
    drained = 0;
    while (crossing_q.size() != 0 && drained < 100000) begin
      @(posedge clk_i); drained++;
    end
    repeat (40) @(posedge clk_i);
    if (fails == 0 && crossing_q.size() == 0)
      $display("[marching_squares_cell_contour_core] OK");
    else
      $display("[marching_squares_cell_contour_core] ERROR");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("[marching_squares_cell_contour_core] ERROR");
    $finish;
  end

endmodule

### marching_squares_cell_contour_core.f
design/msq_pkg.sv
design/msq_frac.sv
design/msq_emit.sv
design/marching_squares_cell_contour_core.sv
design/msq_checker.sv
sim/tb_marching_squares_cell_contour_core.sv
